// ===== design/hierarchical_timer_wheel_defines.svh =====
// assertion macros used by the checker file
`ifndef HIERARCHICAL_TIMER_WHEEL_DEFINES_SVH
`define HIERARCHICAL_TIMER_WHEEL_DEFINES_SVH

// same-cycle implication
`define HTW_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("htw check failed");

// next-cycle implication
`define HTW_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("htw check failed");

`endif

// ===== design/htw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_pkg
// Shared types and constants of the hierarchical timer wheel.
// ----------------------------------------------------------------------------
package htw_pkg;

  localparam int NEAR_BITS_DEF  = 8;
  localparam int WHEEL_BITS_DEF = 6;
  localparam int MAX_TIMERS_DEF = 16;

  localparam int ID_W    = 4;
  localparam int TIME_W  = 32;
  localparam int LEVEL_W = 3;
  localparam int SLOT_W  = 10;
  localparam int ORD_W   = 7;

  localparam logic [LEVEL_W-1:0] LEVEL_NEAR = 3'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_TOP  = 3'd4;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_SETEXP,
    OP_TAKE,
    OP_UNTAKE,
    OP_PLACE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                op;
    logic [LEVEL_W-1:0]      level;
    logic [SLOT_W-1:0]       slot;
    logic [ORD_W-1:0]        order;
    logic [TIME_W-1:0]       expire;
    logic [TIME_W-1:0]       interval;
    logic                    periodic;
  } cell_cmd_t;

  typedef struct packed {
    logic                    valid;
    logic                    taken;
    logic                    match;
    logic [ORD_W-1:0]        order;
    logic [TIME_W-1:0]       expire;
    logic [TIME_W-1:0]       interval;
    logic                    periodic;
  } cell_stat_t;

endpackage

// ===== design/hierarchical_timer_wheel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel
// Timing wheel with a near level and four outer levels over a timer pool.
// ----------------------------------------------------------------------------
// add: a rejected add answers in the next cycle; a filed add passes S_FILEA and S_FILEB.
// tick: steps through S_TAKE and S_NEXT for the near slot and each cascaded level;
//   each refiled timer takes a filing pass through S_FILEA and S_FILEB.
// results appear one per cycle or with refile gaps; the receiver cannot stall.
// reset (synchronous) clears the tick count and every valid flag.
module hierarchical_timer_wheel #(
  parameter int NEAR_BITS  = htw_pkg::NEAR_BITS_DEF,
  parameter int WHEEL_BITS = htw_pkg::WHEEL_BITS_DEF,
  parameter int MAX_TIMERS = htw_pkg::MAX_TIMERS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         func,
  input  logic [htw_pkg::ID_W-1:0]     timer_id,
  input  logic [htw_pkg::TIME_W-1:0]   expire_tick,
  input  logic [htw_pkg::TIME_W-1:0]   repeat_interval,
  input  logic                         periodic,
  output logic                         strobe,
  output logic [htw_pkg::ID_W-1:0]     fired_id,
  output logic                         status,
  output logic                         last
);

  localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam logic [63:0] WMASK = (64'd1 << WHEEL_BITS) - 64'd1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_TAKE  = 5'b00010,
    S_NEXT  = 5'b00100,
    S_FILEA = 5'b01000,
    S_FILEB = 5'b10000
  } state_t;

  state_t                        state;
  logic [htw_pkg::TIME_W-1:0]    tick;
  logic [htw_pkg::LEVEL_W-1:0]   lvl;
  logic [htw_pkg::SLOT_W-1:0]    tslot;
  logic [htw_pkg::SLOT_W-1:0]    nidx;
  logic                          fire_phase;
  logic                          from_add;
  logic [IW-1:0]                 file_id;
  logic [htw_pkg::ORD_W-1:0]     i_cnt;
  logic [htw_pkg::ORD_W-1:0]     n_cnt;
  logic [htw_pkg::LEVEL_W-1:0]   q_level;
  logic [htw_pkg::SLOT_W-1:0]    q_slot;

  htw_pkg::cell_cmd_t            cmd;
  htw_pkg::cell_stat_t           stat [MAX_TIMERS];
  logic [MAX_TIMERS-1:0]         sel;

  logic                          add_ok;
  logic [htw_pkg::ORD_W-1:0]     match_cnt;
  logic                          hit_any;
  logic [IW-1:0]                 hit_id;
  logic [htw_pkg::TIME_W-1:0]    f_exp;
  logic [htw_pkg::TIME_W-1:0]    f_dist;
  logic [htw_pkg::LEVEL_W-1:0]   f_level;
  logic [htw_pkg::SLOT_W-1:0]    f_slot;
  logic                          accept;

  function automatic logic [htw_pkg::SLOT_W-1:0] wheel_slot(
    input logic [htw_pkg::TIME_W-1:0]  t,
    input logic [htw_pkg::LEVEL_W-1:0] lv
  );
    logic [63:0] v;
    v = 64'(t);
    case (lv)
      3'd1:    v = v >> NEAR_BITS;
      3'd2:    v = v >> (NEAR_BITS + WHEEL_BITS);
      3'd3:    v = v >> (NEAR_BITS + 2 * WHEEL_BITS);
      default: v = v >> (NEAR_BITS + 3 * WHEEL_BITS);
    endcase
    return htw_pkg::SLOT_W'(v & WMASK);
  endfunction

  genvar g;
  generate
    for (g = 0; g < MAX_TIMERS; g++) begin : g_cell
      htw_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .sel  (sel[g]),
        .cmd  (cmd),
        .stat (stat[g])
      );
    end
  endgenerate

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    add_ok    = (32'(timer_id) < MAX_TIMERS);
    match_cnt = '0;
    hit_any   = 1'b0;
    hit_id    = '0;
    for (int c = 0; c < MAX_TIMERS; c++) begin
      if (32'(timer_id) == c && stat[c].valid) add_ok = 1'b0;
      match_cnt = match_cnt + htw_pkg::ORD_W'(stat[c].match);
      if (stat[c].taken && stat[c].order == i_cnt) begin
        hit_any = 1'b1;
        hit_id  = IW'(c);
      end
    end
  end

  // filing place of the timer in file_id
  always_comb begin
    f_exp   = stat[file_id].expire;
    f_dist  = f_exp - tick;
    f_level = htw_pkg::LEVEL_TOP;
    f_slot  = '0;
    if (f_dist[htw_pkg::TIME_W-1]) begin
      f_level = htw_pkg::LEVEL_NEAR;
      f_slot  = htw_pkg::SLOT_W'(tick[NEAR_BITS-1:0]);
    end else if (64'(f_dist) < (64'd1 << NEAR_BITS)) begin
      f_level = htw_pkg::LEVEL_NEAR;
      f_slot  = htw_pkg::SLOT_W'(f_exp[NEAR_BITS-1:0]);
    end else begin
      for (int k = 3; k >= 1; k--) begin
        if (64'(f_dist) < (64'd1 << (NEAR_BITS + k * WHEEL_BITS)))
          f_level = htw_pkg::LEVEL_W'(k);
      end
      f_slot = wheel_slot(f_exp, f_level);
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.op       = htw_pkg::OP_NOP;
    cmd.level    = q_level;
    cmd.slot     = q_slot;
    cmd.order    = match_cnt;
    cmd.expire   = expire_tick;
    cmd.interval = repeat_interval;
    cmd.periodic = periodic;
    sel          = '0;
    case (state)
      S_IDLE: begin
        if (accept && func && add_ok) begin
          cmd.op = htw_pkg::OP_LOAD;
          for (int c = 0; c < MAX_TIMERS; c++)
            sel[c] = (32'(timer_id) == c);
        end
      end
      S_TAKE: cmd.op = htw_pkg::OP_TAKE;
      S_NEXT: begin
        if (i_cnt != n_cnt && hit_any) begin
          sel[hit_id] = 1'b1;
          if (fire_phase && stat[hit_id].periodic) begin
            cmd.op     = htw_pkg::OP_SETEXP;
            cmd.expire = stat[hit_id].interval + tick;
          end else begin
            cmd.op = htw_pkg::OP_UNTAKE;
          end
        end
      end
      S_FILEB: begin
        cmd.op        = htw_pkg::OP_PLACE;
        sel[file_id]  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      tick   <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (func) begin
              if (add_ok) begin
                file_id  <= IW'(timer_id);
                from_add <= 1'b1;
                state    <= S_FILEA;
              end else begin
                strobe   <= 1'b1;
                fired_id <= timer_id;
                status   <= 1'b1;
                last     <= 1'b1;
              end
            end else begin
              from_add <= 1'b0;
              nidx     <= htw_pkg::SLOT_W'(tick[NEAR_BITS-1:0]);
              state    <= S_TAKE;
              if (tick[NEAR_BITS-1:0] == '0) begin
                fire_phase <= 1'b0;
                lvl        <= 3'd1;
                q_level    <= 3'd1;
                q_slot     <= wheel_slot(tick, 3'd1);
                tslot      <= wheel_slot(tick, 3'd1);
              end else begin
                fire_phase <= 1'b1;
                tick       <= tick + 1'b1;
                q_level    <= htw_pkg::LEVEL_NEAR;
                q_slot     <= htw_pkg::SLOT_W'(tick[NEAR_BITS-1:0]);
              end
            end
          end
        end
        S_TAKE: begin
          n_cnt <= match_cnt;
          i_cnt <= '0;
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (i_cnt == n_cnt || !hit_any) begin
            if (fire_phase) begin
              state <= S_IDLE;
            end else if (lvl == htw_pkg::LEVEL_TOP || tslot != '0) begin
              // cascade done, advance and fire the near slot
              fire_phase <= 1'b1;
              tick       <= tick + 1'b1;
              q_level    <= htw_pkg::LEVEL_NEAR;
              q_slot     <= nidx;
              state      <= S_TAKE;
            end else begin
              lvl     <= lvl + 1'b1;
              q_level <= lvl + 1'b1;
              q_slot  <= wheel_slot(tick, lvl + 1'b1);
              tslot   <= wheel_slot(tick, lvl + 1'b1);
              state   <= S_TAKE;
            end
          end else begin
            i_cnt   <= i_cnt + 1'b1;
            file_id <= hit_id;
            if (fire_phase) begin
              strobe   <= 1'b1;
              fired_id <= htw_pkg::ID_W'(hit_id);
              status   <= 1'b0;
              last     <= (i_cnt + 1'b1 == n_cnt);
              if (stat[hit_id].periodic) state <= S_FILEA;
            end else begin
              state <= S_FILEA;
            end
          end
        end
        S_FILEA: begin
          q_level <= f_level;
          q_slot  <= f_slot;
          state   <= S_FILEB;
        end
        S_FILEB: begin
          state <= from_add ? S_IDLE : S_NEXT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/htw_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_cell
// One timer of the pool: its filing place, order and timing fields.
// ----------------------------------------------------------------------------
module htw_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                sel,
  input  htw_pkg::cell_cmd_t  cmd,
  output htw_pkg::cell_stat_t stat
);

  logic                          valid;
  logic                          taken;
  logic [htw_pkg::LEVEL_W-1:0]   level;
  logic [htw_pkg::SLOT_W-1:0]    slot;
  logic [htw_pkg::ORD_W-1:0]     order;
  logic [htw_pkg::TIME_W-1:0]    expire;
  logic [htw_pkg::TIME_W-1:0]    interval;
  logic                          periodic;
  logic                          match;

  assign match = valid && (level == cmd.level) && (slot == cmd.slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      taken <= 1'b0;
    end else begin
      case (cmd.op)
        htw_pkg::OP_TAKE: begin
          if (match) begin
            valid <= 1'b0;
            taken <= 1'b1;
          end
        end
        htw_pkg::OP_UNTAKE, htw_pkg::OP_SETEXP: begin
          if (sel) taken <= 1'b0;
        end
        htw_pkg::OP_PLACE: begin
          if (sel) valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      case (cmd.op)
        htw_pkg::OP_LOAD: begin
          expire   <= cmd.expire;
          interval <= cmd.interval;
          periodic <= cmd.periodic;
        end
        htw_pkg::OP_SETEXP: expire <= cmd.expire;
        htw_pkg::OP_PLACE: begin
          level <= cmd.level;
          slot  <= cmd.slot;
          order <= cmd.order;
        end
        default: ;
      endcase
    end
  end

  assign stat.valid    = valid;
  assign stat.taken    = taken;
  assign stat.match    = match;
  assign stat.order    = order;
  assign stat.expire   = expire;
  assign stat.interval = interval;
  assign stat.periodic = periodic;

endmodule

// ===== design/htw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_checker
// Port-level checks of the timer wheel, bound to the top level.
// ----------------------------------------------------------------------------
`include "hierarchical_timer_wheel_defines.svh"

module htw_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic func,
  input logic strobe,
  input logic status,
  input logic last
);

  // a rejected add is a single result
  `HTW_ASSERT_NOW(a_reject_last, clk, rst, strobe && status, last)
  // a rejection follows an add transfer
  `HTW_ASSERT_NOW(a_reject_src, clk, rst, strobe && status, $past(start && !busy && func))
  // expiries come out of a tick in progress
  `HTW_ASSERT_NOW(a_fire_busy, clk, rst, strobe && !status, $past(busy))
  // each transfer either starts work or answers at once
  `HTW_ASSERT_NEXT(a_accept, clk, rst, start && !busy, busy || strobe)

endmodule

bind hierarchical_timer_wheel htw_checker u_htw_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .func   (func),
  .strobe (strobe),
  .status (status),
  .last   (last)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives tick and add commands into the timer wheel with random gaps, keeps
// its own copy of the wheel state to predict fired and rejected ids, and
// checks every strobed result in order against that prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NB = htw_pkg::NEAR_BITS_DEF;
  localparam int WB = htw_pkg::WHEEL_BITS_DEF;
  localparam int NT = htw_pkg::MAX_TIMERS_DEF;
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_ADD  = 1'b1;
  localparam logic ST_FIRED  = 1'b0;
  localparam logic ST_BUSY   = 1'b1;
  localparam int IDLE_LIMIT  = 5000;

  typedef struct {
    logic [htw_pkg::ID_W-1:0] id;
    logic            st;
    logic            lst;
  } fire_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic func;
  logic [htw_pkg::ID_W-1:0] timer_id;
  logic [htw_pkg::TIME_W-1:0] expire_tick;
  logic [htw_pkg::TIME_W-1:0] repeat_interval;
  logic periodic;
  logic strobe;
  logic [htw_pkg::ID_W-1:0] fired_id;
  logic status;
  logic last;

  // wheel state as predicted
  logic [31:0] wheel_tick;
  logic        t_valid[NT];
  logic [31:0] t_expire[NT];
  logic [31:0] t_interval[NT];
  logic        t_periodic[NT];
  logic [2:0]  t_level[NT];
  logic [7:0]  t_slot[NT];
  int          t_order[NT];

  fire_t expected_fires[$];
  int    slot_ids[NT];
  int    errors = 0;
  int    idle_cycles = 0;

  hierarchical_timer_wheel u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .timer_id(timer_id), .expire_tick(expire_tick),
    .repeat_interval(repeat_interval), .periodic(periodic),
    .strobe(strobe), .fired_id(fired_id), .status(status), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void file_timer(int id);
    logic [31:0] delta;
    logic [2:0]  lvl;
    logic [7:0]  slt;
    int          rank;
    delta = t_expire[id] - wheel_tick;
    rank = 0;
    if (delta[31]) begin
      lvl = 3'd0;
      slt = wheel_tick[7:0];
    end else if (delta < (32'd1 << NB)) begin
      lvl = 3'd0;
      slt = t_expire[id][7:0];
    end else begin
      lvl = 3'd4;
      for (int k = 3; k >= 1; k--)
        if (64'(delta) < (64'd1 << (NB + k * WB))) lvl = 3'(k);
      slt = 8'((t_expire[id] >> (NB + (lvl - 1) * WB)) & ((1 << WB) - 1));
    end
    for (int k = 0; k < NT; k++)
      if (t_valid[k] && t_level[k] == lvl && t_slot[k] == slt) rank++;
    t_level[id] = lvl;
    t_slot[id] = slt;
    t_order[id] = rank;
    t_valid[id] = 1'b1;
  endfunction

  // empties one slot into slot_ids in filing order
  function automatic int take_slot(logic [2:0] lvl, logic [7:0] slt);
    int n;
    n = 0;
    for (int k = 0; k < NT; k++)
      if (t_valid[k] && t_level[k] == lvl && t_slot[k] == slt) n++;
    for (int k = 0; k < NT; k++)
      if (t_valid[k] && t_level[k] == lvl && t_slot[k] == slt) begin
        if (t_order[k] < n) slot_ids[t_order[k]] = k;
        t_valid[k] = 1'b0;
      end
    return n;
  endfunction

  function automatic void queue_result(fire_t r);
    expected_fires.insert(expected_fires.size(), r);
  endfunction

  function automatic void predict_wheel(logic f, logic [3:0] id, logic [31:0] ex,
                                        logic [31:0] iv, logic per);
    int          n;
    int          ids[NT];
    logic [7:0]  idx;
    logic [7:0]  s;
    fire_t       r;
    if (f == FUNC_ADD) begin
      if (int'(id) >= NT || t_valid[id]) begin
        r.id = id; r.st = ST_BUSY; r.lst = 1'b1;
        queue_result(r);
      end else begin
        t_expire[id] = ex;
        t_interval[id] = iv;
        t_periodic[id] = per;
        file_timer(id);
      end
    end else begin
      idx = wheel_tick[7:0];
      if (idx == 0) begin
        for (int k = 0; k < 4; k++) begin
          s = 8'((wheel_tick >> (NB + k * WB)) & ((1 << WB) - 1));
          n = take_slot(3'(k + 1), s);
          for (int i = 0; i < n; i++) ids[i] = slot_ids[i];
          for (int i = 0; i < n; i++) file_timer(ids[i]);
          if (s != 0) break;
        end
      end
      wheel_tick = wheel_tick + 1;
      n = take_slot(3'd0, idx);
      for (int i = 0; i < n; i++) ids[i] = slot_ids[i];
      for (int i = 0; i < n; i++) begin
        r.id = 4'(ids[i]); r.st = ST_FIRED; r.lst = (i == n - 1);
        queue_result(r);
        if (t_periodic[ids[i]]) begin
          t_expire[ids[i]] = t_interval[ids[i]] + wheel_tick;
          file_timer(ids[i]);
        end
      end
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    fire_t e;
    if (!rst && strobe) begin
      if (expected_fires.size() == 0) begin
        report_mismatch($sformatf("unexpected result id %0d status %0d", fired_id, status));
      end else begin
        e = expected_fires.pop_front();
        if (fired_id !== e.id || status !== e.st || last !== e.lst)
          report_mismatch($sformatf("got id %0d st %0d last %0d, want %0d %0d %0d",
                                    fired_id, status, last, e.id, e.st, e.lst));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired");
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_cmd(logic f, logic [3:0] id, logic [31:0] ex, logic [31:0] iv,
                          logic per, int gap);
    start <= 1'b1;
    func <= f;
    timer_id <= id;
    expire_tick <= ex;
    repeat_interval <= iv;
    periodic <= per;
    do @(posedge clk); while (busy);
    predict_wheel(f, id, ex, iv, per);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_fires.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic add_timer(logic [3:0] id, logic [31:0] dist_ticks, logic [31:0] iv,
                           logic per);
    send_cmd(FUNC_ADD, id, wheel_tick + dist_ticks, iv, per, pick_gap());
  endtask

  task automatic tick_once(int gap);
    send_cmd(FUNC_TICK, 4'($urandom), $urandom, $urandom, 1'($urandom), gap);
  endtask

  task automatic test_directed();
    add_timer(4'd0, 32'd0, 32'd0, 1'b0);
    add_timer(4'd15, 32'd1, 32'hFFFF_FFFF, 1'b0);
    add_timer(4'd3, 32'hFFFF_FFFF, 32'd0, 1'b0);      // already passed
    add_timer(4'd0, 32'd5, 32'd0, 1'b0);              // id busy
    add_timer(4'd4, 32'h8000_0000, 32'd0, 1'b0);      // past by sign
    add_timer(4'd5, 32'h7FFF_FFFF, 32'd0, 1'b0);      // top level
    add_timer(4'd6, 32'd255, 32'd0, 1'b0);
    add_timer(4'd7, 32'd256, 32'd0, 1'b0);            // first outer level
    add_timer(4'd8, 32'd2, 32'd3, 1'b1);              // periodic
    add_timer(4'd9, 32'd2, 32'd0, 1'b1);              // periodic, zero interval
    add_timer(4'd10, 32'h3FFF, 32'd0, 1'b0);
    add_timer(4'd11, 32'h4000, 32'd0, 1'b0);          // second outer level
    add_timer(4'd12, 32'h100000, 32'd0, 1'b0);        // third outer level
    repeat (8) tick_once(pick_gap());
    add_timer(4'd9, 32'd1, 32'd0, 1'b0);              // still rearmed, busy
    repeat (4) tick_once(0);
  endtask

  task automatic test_random(int count);
    int p;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 55) begin
        tick_once(pick_gap());
      end else begin
        p = $urandom_range(0, 99);
        add_timer(4'($urandom),
                  p < 70 ? 32'($urandom_range(0, 300)) :
                  p < 82 ? 32'($urandom_range(0, 20000)) :
                  p < 95 ? -32'($urandom_range(1, 500)) : 32'($urandom),
                  $urandom_range(0, 9) == 0 ? 32'($urandom) : 32'($urandom_range(0, 40)),
                  $urandom_range(0, 2) == 0);
      end
    end
  endtask

  // runs past the near level wrap so a first outer level slot cascades
  task automatic test_long_run();
    add_timer(4'd13, 32'd150, 32'd0, 1'b0);
    add_timer(4'd14, 32'd300, 32'd0, 1'b0);
    add_timer(4'd2, 32'h8000, 32'd0, 1'b0);
    while (wheel_tick < 32'h0104) tick_once(0);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    func = 1'b0;
    timer_id = '0;
    expire_tick = '0;
    repeat_interval = '0;
    periodic = 1'b0;
    wheel_tick = '0;
    for (int k = 0; k < NT; k++) t_valid[k] = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(100);
    wait_drained();
    test_long_run();
    test_random(40);
    wait_drained();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
